/* src/ucr_pkg.sv */
// Shared types, constants and the UTF-8 encoder function of the codepoint remapper.
// Has no dependencies; every other file of the block imports it.
package ucr_pkg;

    // Kind codes of an input item.
    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // Replacement character and the three bytes that encode it.
    localparam logic [20:0] REPL_CP = 21'h00FFFD;
    localparam logic [3:0][7:0] REPL_BYTES = {8'h00, 8'hBD, 8'hBF, 8'hEF};

    // Lead byte class boundaries.
    localparam logic [7:0] LEAD_CONT  = 8'h80;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_BAD   = 8'hF8;

    // Encoding range limits.
    localparam logic [20:0] LIMIT_ONE   = 21'h000080;
    localparam logic [20:0] LIMIT_TWO   = 21'h000800;
    localparam logic [20:0] LIMIT_THREE = 21'h010000;

    // One input item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic        end_of_text;
        logic [7:0]  entry_index;
        logic [20:0] entry_source;
        logic [20:0] entry_target;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Request to the byte emitter: up to four bytes, byte 0 goes out first.
    typedef struct packed {
        logic            load;
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
        logic            last;
    } emit_load_t;

    // Answer of the table search unit.
    typedef struct packed {
        logic        done;
        logic [20:0] target;
    } search_rsp_t;

    // What follows the optional broken-sequence replacement of an item.
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_REPL = 2'd1,
        TAIL_CP   = 2'd2
    } tail_kind_t;

    // Emitter request for the replacement sequence.
    function automatic emit_load_t repl_load(input logic last);
        emit_load_t r;
        r       = '0;
        r.load  = 1'b1;
        r.bytes = REPL_BYTES;
        r.len   = 3'd3;
        r.last  = last;
        return r;
    endfunction

    // Emitter request for the UTF-8 form of a codepoint; always ends the item.
    function automatic emit_load_t encode_cp(input logic [20:0] cp);
        emit_load_t r;
        r      = '0;
        r.load = 1'b1;
        r.last = 1'b1;
        if (cp < LIMIT_ONE)
        begin
            r.bytes[0] = {1'b0, cp[6:0]};
            r.len      = 3'd1;
        end
        else if (cp < LIMIT_TWO)
        begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.len      = 3'd2;
        end
        else if (cp < LIMIT_THREE)
        begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.len      = 3'd3;
        end
        else
        begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.len      = 3'd4;
        end
        return r;
    endfunction

endpackage

/* src/utf8_codepoint_remapper_unit.sv */
// Top level of the UTF-8 codepoint remapper: decoder, sequencer and channel ports.
// Depends on ucr_pkg, ucr_search and ucr_emitter.
//
//  Channel   Signals                                 Direction   Moves
//  input     in_valid, in_stall, in_item             in          one text byte or table entry
//  output    out_valid, out_stall, out_item          out         one UTF-8 output byte
//  config    cfg_write_en, cfg_write_data            in          entry_count register
//
// A table entry write and a text byte that only extends a sequence each leave the unit ready for the next item.
// A byte that completes a codepoint holds the input until its tail is handed over once the emitter is free
// and the table search has answered: the binary search probes one table entry per
// cycle through the registered read port of the table memory; the bytes then drain through the
// emitter while the next item comes in.
// A replacement sequence is handed over to the emitter, which then drains its three bytes.
// Reset clears the decoder and entry_count; the table is not cleared.
// Output stalls hold the emitter, and the next item waits only when a new chunk needs it.
module utf8_codepoint_remapper_unit
    import ucr_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_write_en,
    input  logic [8:0] cfg_write_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_PRE  = 4'b0010,
        T_TAIL = 4'b0100,
        T_LOOK = 4'b1000
    } top_state_t;

    top_state_t  state_reg, state_next;
    logic [1:0]  pending_reg, pending_next;
    logic [20:0] partial_reg, partial_next;
    logic [8:0]  entry_count_reg;
    tail_kind_t  tail_reg, tail_next;
    logic [20:0] cp_reg, cp_next;

    logic        in_accept;
    logic        text_accept;
    logic        pre_repl;
    logic [7:0]  b;
    logic        is_cont;
    logic [1:0]  cont_pending;
    logic [20:0] cont_partial;
    logic [31:0] idx_wide;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] count_eff;

    emit_load_t  emit_load;
    logic        emit_busy;
    logic        search_start;
    search_rsp_t search_rsp;

    assign in_stall    = (state_reg != T_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign text_accept = in_accept && (in_item.kind == KIND_TEXT);

    assign b            = in_item.text_byte;
    assign is_cont      = (b[7:6] == 2'b10);
    assign cont_pending = pending_reg - 2'd1;
    assign cont_partial = {partial_reg[14:0], b[5:0]};

    // Decoder: new sequence state and the work this byte causes.
    always_comb
    begin
        pre_repl     = 1'b0;
        tail_next    = TAIL_NONE;
        cp_next      = {13'd0, b};
        pending_next = pending_reg;
        partial_next = partial_reg;
        if ((pending_reg != 2'd0) && is_cont)
        begin
            if (cont_pending == 2'd0)
            begin
                tail_next    = TAIL_CP;
                cp_next      = cont_partial;
                pending_next = 2'd0;
                partial_next = '0;
            end
            else
            begin
                pending_next = cont_pending;
                partial_next = cont_partial;
            end
        end
        else
        begin
            // A broken sequence is replaced, then the byte starts afresh.
            pre_repl     = (pending_reg != 2'd0);
            pending_next = 2'd0;
            partial_next = '0;
            if (b < LEAD_CONT)
            begin
                tail_next = TAIL_CP;
            end
            else if (b < LEAD_TWO)
            begin
                tail_next = TAIL_REPL;
            end
            else if (b < LEAD_THREE)
            begin
                pending_next = 2'd1;
                partial_next = {16'd0, b[4:0]};
            end
            else if (b < LEAD_FOUR)
            begin
                pending_next = 2'd2;
                partial_next = {17'd0, b[3:0]};
            end
            else if (b < LEAD_BAD)
            begin
                pending_next = 2'd3;
                partial_next = {18'd0, b[2:0]};
            end
            else
            begin
                tail_next = TAIL_REPL;
            end
        end

        // A sequence left open at the end of the text is replaced.
        if (in_item.end_of_text && (pending_next != 2'd0))
        begin
            tail_next    = TAIL_REPL;
            pending_next = 2'd0;
            partial_next = '0;
        end
    end

    // Sequencer: hand chunks to the emitter and run the table search.
    always_comb
    begin
        state_next   = state_reg;
        emit_load    = '0;
        search_start = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (text_accept)
                begin
                    if (pre_repl)
                    begin
                        state_next = T_PRE;
                    end
                    else if (tail_next != TAIL_NONE)
                    begin
                        state_next = T_TAIL;
                    end
                end
            end
            T_PRE:
            begin
                if (!emit_busy)
                begin
                    emit_load  = repl_load(tail_reg == TAIL_NONE);
                    state_next = (tail_reg == TAIL_NONE) ? T_IDLE : T_TAIL;
                end
            end
            T_TAIL:
            begin
                if (!emit_busy)
                begin
                    if ((tail_reg == TAIL_REPL) || (cp_reg == REPL_CP))
                    begin
                        emit_load  = repl_load(1'b1);
                        state_next = T_IDLE;
                    end
                    else
                    begin
                        search_start = 1'b1;
                        state_next   = T_LOOK;
                    end
                end
            end
            T_LOOK:
            begin
                if (search_rsp.done)
                begin
                    emit_load  = encode_cp(search_rsp.target);
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            pending_reg     <= 2'd0;
            partial_reg     <= '0;
            entry_count_reg <= 9'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (text_accept)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
            if (cfg_write_en)
            begin
                entry_count_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            tail_reg <= tail_next;
            cp_reg   <= cp_next;
        end
    end

    // Table writes and the saturated entry count.
    assign idx_wide  = 32'(in_item.entry_index);
    assign wr_en     = in_accept && (in_item.kind == KIND_ENTRY)
                       && (idx_wide < 32'(TABLE_DEPTH));
    assign wr_addr   = idx_wide[AW-1:0];
    assign count_eff = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                                  : CW'(entry_count_reg);

    ucr_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_source (in_item.entry_source),
        .wr_target (in_item.entry_target),
        .start     (search_start),
        .cp        (cp_reg),
        .count     (count_eff),
        .rsp       (search_rsp)
    );

    ucr_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit_load),
        .busy      (emit_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Search answers arrive only while the sequencer waits for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        search_rsp.done |-> (state_reg == T_LOOK))
        else $error("search answer outside lookup wait");

endmodule

/* src/ucr_search.sv */
// Remap table memory and the lower-bound binary search unit, one probe per cycle.
// Depends on ucr_pkg for the search response type.
module ucr_search
    import ucr_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [20:0]         wr_source,
    input  logic [20:0]         wr_target,
    input  logic                start,
    input  logic [20:0]         cp,
    input  logic [CW-1:0]       count,
    output search_rsp_t         rsp
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_CHECK = 3'b100
    } search_state_t;

    search_state_t state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [20:0]   cp_reg, cp_next;

    logic [20:0] src_mem [TABLE_DEPTH];
    logic [20:0] tgt_mem [TABLE_DEPTH];
    logic [20:0] rd_src_reg;
    logic [20:0] rd_tgt_reg;

    logic          less;
    logic [CW-1:0] lo_step;
    logic [CW-1:0] hi_step;
    logic [CW:0]   step_sum;
    logic [CW-1:0] step_mid;
    logic [CW-1:0] rd_wide;
    logic [AW-1:0] rd_addr;
    logic          hit;

    // Shared compare and midpoint unit for one probe.
    assign less     = rd_src_reg < cp_reg;
    assign lo_step  = less ? (mid_reg + CW'(1)) : lo_reg;
    assign hi_step  = less ? hi_reg : mid_reg;
    assign step_sum = {1'b0, lo_step} + {1'b0, hi_step};
    assign step_mid = step_sum[CW:1];

    // Probe sequencer; the next probe address is issued in the same cycle.
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        count_next = count_reg;
        cp_next    = cp_reg;
        rd_wide    = count >> 1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = count;
                    count_next = count;
                    cp_next    = cp;
                    mid_next   = count >> 1;
                    state_next = (count != '0) ? S_PROBE : S_CHECK;
                end
            end
            S_PROBE:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next = step_mid;
                    rd_wide  = step_mid;
                end
                else
                begin
                    rd_wide    = lo_step;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = rd_wide[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        count_reg <= count_next;
        cp_reg    <= cp_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_mem[wr_addr] <= wr_source;
            tgt_mem[wr_addr] <= wr_target;
        end
        rd_src_reg <= src_mem[rd_addr];
        rd_tgt_reg <= tgt_mem[rd_addr];
    end

    // Final check of the lower-bound slot.
    assign hit        = (lo_reg < count_reg) && (rd_src_reg == cp_reg);
    assign rsp.done   = (state_reg == S_CHECK);
    assign rsp.target = hit ? rd_tgt_reg : cp_reg;

    // The search window never collapses while a probe is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg < hi_reg))
        else $error("search window empty during a probe");

    // A new search is only started when the unit is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("search started while busy");

endmodule

/* src/ucr_emitter.sv */
// Byte emitter: holds up to four bytes of one chunk and feeds the output register.
// Depends on ucr_pkg for the emitter request and result item types.
module ucr_emitter
    import ucr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_load_t load,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    logic            active_reg;
    logic            out_valid_reg;
    logic [3:0][7:0] buf_reg;
    logic [2:0]      len_reg;
    logic            last_reg;
    logic [1:0]      idx_reg;
    out_item_t       out_item_reg;

    logic advance;
    logic final_byte;

    // A byte moves into the output register when that register is free or being taken.
    assign advance    = active_reg && (!out_valid_reg || !out_stall);
    assign final_byte = ({1'b0, idx_reg} == (len_reg - 3'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load.load)
            begin
                active_reg <= 1'b1;
            end
            else if (advance && final_byte)
            begin
                active_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Chunk buffer and output payload.
    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            buf_reg  <= load.bytes;
            len_reg  <= load.len;
            last_reg <= load.last;
            idx_reg  <= 2'd0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + 2'd1;
        end

        if (advance)
        begin
            out_item_reg.out_byte    <= buf_reg[idx_reg];
            out_item_reg.last_of_run <= last_reg && final_byte;
        end
    end

    assign busy      = active_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A new chunk never overwrites bytes still waiting to go out.
    assert property (@(posedge clk) disable iff (!rst_n)
        load.load |-> !active_reg)
        else $error("emitter loaded while busy");

    // The byte pointer stays inside the loaded chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ({1'b0, idx_reg} < len_reg))
        else $error("emitter index past chunk length");

endmodule
